FILE: hdl/arcodo_pkg.sv
// Shared types and constants for the arc odometry integrator.
// No dependencies; imported by the core and its checker.
package arcodo_pkg;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_WB   = 6'b010000,
        ST_UPD  = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        OP_SPEED,
        OP_DTH,
        OP_SIN,
        OP_VX,
        OP_VY,
        OP_DX,
        OP_DY,
        OP_W,
        OP_AX,
        OP_QX,
        OP_AY,
        OP_QY
    } op_t;

    localparam logic [31:0] QUARTER_TURN     = 32'h4000_0000;
    localparam logic [31:0] TURN_PER_RAD_Q16 = 32'd683565276;
    localparam logic [31:0] SIN_TOP_COEF     = 32'd172273;
    localparam logic [30:0] ONE_Q30          = 31'h4000_0000;
    localparam logic [31:0] HALF_HEADING     = 32'h0000_8000;
    localparam logic [2:0]  SIN_LAST_STEP    = 3'd5;
    localparam logic [5:0]  MUL_LAST         = 6'd31;
    localparam logic [5:0]  DIV_LAST         = 6'd63;

    // Constant term of Horner steps 1 to 4 of the sine polynomial; the product is subtracted from it.
    function automatic logic [31:0] sin_coef(input logic [2:0] k);
        logic [31:0] c;
        case (k)
            3'd1:    c = 32'd5026995;
            3'd2:    c = 32'd85569306;
            3'd3:    c = 32'd693598670;
            3'd4:    c = 32'd1686629713;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/arc_odometry_integrator_core.sv
// Arc odometry integrator core: pose update from encoder pulses and yaw rate.
// Depends on arcodo_pkg; contains its own bit-serial multiplier and divider.
//
// An update on a curved path (nonzero yaw rate) runs more steps than one on
// a straight path (zero yaw rate). A finished result beat is offered in the
// same cycle that the next input beat can first be taken. All products go
// through one shift-add multiplier that retires one multiplier bit per cycle.
// The arc path adds two restoring divisions by the yaw rate at one quotient
// bit per cycle. Twenty-four of the products are the four sine evaluations
// of a quarter-wave polynomial, which make up most of the multiplier work of
// an update. The block holds one update at a time: s_ready is high only while
// the sequencer is idle, and a finished pose waits in the output register so
// that the next item can be accepted before the result is taken. The speed
// register is written through the cfg port, which is always ready, and must
// only be written while no update is in flight.
module arc_odometry_integrator_core
    import arcodo_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_pulse_count,
    input  logic signed [23:0] s_yaw_rate,
    input  logic [15:0]        s_elapsed_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic [15:0]        m_heading,
    output logic signed [31:0] m_vel_x,
    output logic signed [31:0] m_vel_y
);

    // Angle bits below the ANGLE_BITS angle resolution are dropped.
    localparam logic [29:0] ANG_MASK = 30'(32'hFFFF_FFFF << (32 - ANGLE_BITS));
    localparam logic signed [63:0] DELTA_LIMIT = 64'sd1 << 40;

    // Control state.
    state_t      state_reg;
    op_t         op_reg;
    logic [2:0]  ksub_reg;
    logic [1:0]  sidx_reg;
    logic [5:0]  cnt_reg;
    logic        m_valid_reg;

    // Configuration and the latched input beat.
    logic [31:0]        spp_reg;
    logic signed [15:0] pulse_reg;
    logic signed [23:0] omega_reg;
    logic [15:0]        dt_reg;

    // Pose state.
    logic signed [31:0] posx_reg;
    logic signed [31:0] posy_reg;
    logic [15:0]        head_reg;

    // Intermediate results.
    logic [47:0]        vmag_reg;
    logic               vneg_reg;
    logic [31:0]        dth_reg;
    logic [30:0]        x2_reg;
    logic [31:0]        t_reg;
    logic signed [31:0] sin_reg [4];
    logic signed [47:0] vx_reg;
    logic signed [47:0] vy_reg;
    logic [60:0]        w_reg;
    logic [63:0]        num_reg;
    logic               numneg_reg;
    logic signed [63:0] dx_reg;
    logic signed [63:0] dy_reg;

    // Shift-add multiplier and restoring divider.
    logic [63:0] ma_reg;
    logic [63:0] mhi_reg;
    logic [31:0] mlo_reg;
    logic [63:0] dn_reg;
    logic [23:0] drem_reg;
    logic [23:0] dd_reg;

    // Output register.
    logic signed [31:0] outx_reg, outy_reg, outvx_reg, outvy_reg;
    logic [15:0]        outh_reg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] clamp_delta(input logic signed [63:0] d);
        logic signed [63:0] r;
        if (d > DELTA_LIMIT) begin
            r = DELTA_LIMIT;
        end else if (d < -DELTA_LIMIT) begin
            r = -DELTA_LIMIT;
        end else begin
            r = d;
        end
        return r;
    endfunction

    // Magnitudes of the signed operands.
    logic [15:0] pulse_mag;
    logic [23:0] omega_mag;
    logic [47:0] vx_mag, vy_mag;
    logic [31:0] c0_mag, s0_mag;
    logic signed [32:0] diffx, diffy;
    logic [31:0] diffx_mag, diffy_mag;

    assign pulse_mag = pulse_reg[15] ? 16'(-pulse_reg) : 16'(pulse_reg);
    assign omega_mag = omega_reg[23] ? 24'(-omega_reg) : 24'(omega_reg);
    assign vx_mag    = vx_reg[47] ? 48'(-vx_reg) : 48'(vx_reg);
    assign vy_mag    = vy_reg[47] ? 48'(-vy_reg) : 48'(vy_reg);
    assign s0_mag    = sin_reg[0][31] ? 32'(-sin_reg[0]) : 32'(sin_reg[0]);
    assign c0_mag    = sin_reg[1][31] ? 32'(-sin_reg[1]) : 32'(sin_reg[1]);
    assign diffx     = 33'(sin_reg[2]) - 33'(sin_reg[0]);
    assign diffy     = 33'(sin_reg[1]) - 33'(sin_reg[3]);
    assign diffx_mag = diffx[32] ? 32'(-diffx) : 32'(diffx);
    assign diffy_mag = diffy[32] ? 32'(-diffy) : 32'(diffy);

    // Angle that the current sine evaluation works on and its reduced argument.
    logic [31:0] th0, th1, sin_ang;
    logic [29:0] xm;
    logic [30:0] x_val;

    assign th0 = {head_reg, 16'h0000};
    assign th1 = th0 + dth_reg;

    always_comb begin
        case (sidx_reg)
            2'd0:    sin_ang = th0;
            2'd1:    sin_ang = th0 + QUARTER_TURN;
            2'd2:    sin_ang = th1;
            default: sin_ang = th1 + QUARTER_TURN;
        endcase
    end

    assign xm    = sin_ang[29:0] & ANG_MASK;
    assign x_val = sin_ang[30] ? ONE_Q30 - {1'b0, xm} : {1'b0, xm};

    // Multiplier operand selection for the current micro-op.
    logic [63:0] op_a;
    logic [31:0] op_b;

    always_comb begin
        op_a = 64'd0;
        op_b = 32'd0;
        unique case (op_reg)
            OP_SPEED: begin
                op_a = 64'(spp_reg);
                op_b = 32'(pulse_mag);
            end
            OP_DTH: begin
                op_a = 64'(omega_mag);
                op_b = 32'(dt_reg);
            end
            OP_SIN: begin
                if (ksub_reg == 3'd0) begin
                    op_a = 64'(x_val);
                    op_b = 32'(x_val);
                end else if (ksub_reg == 3'd1) begin
                    op_a = 64'(x2_reg);
                    op_b = SIN_TOP_COEF;
                end else if (ksub_reg == SIN_LAST_STEP) begin
                    op_a = 64'(x_val);
                    op_b = t_reg;
                end else begin
                    op_a = 64'(x2_reg);
                    op_b = t_reg;
                end
            end
            OP_VX: begin
                op_a = 64'(vmag_reg);
                op_b = c0_mag;
            end
            OP_VY: begin
                op_a = 64'(vmag_reg);
                op_b = s0_mag;
            end
            OP_DX: begin
                op_a = 64'(vx_mag);
                op_b = 32'(dt_reg);
            end
            OP_DY: begin
                op_a = 64'(vy_mag);
                op_b = 32'(dt_reg);
            end
            OP_W: begin
                op_a = 64'(vmag_reg);
                op_b = TURN_PER_RAD_Q16;
            end
            OP_AX: begin
                op_a = 64'(w_reg);
                op_b = diffx_mag;
            end
            OP_AY: begin
                op_a = 64'(w_reg);
                op_b = diffy_mag;
            end
            default: begin
                op_a = 64'd0;
                op_b = 32'd0;
            end
        endcase
    end

    // Full product and the datapath values derived from it.
    logic [95:0] prod;
    logic [64:0] msum;
    logic [24:0] dshift;
    logic        dge;
    logic [31:0] sin_r;
    logic [31:0] sin_clamped;
    logic [47:0] vel_mag;
    logic [46:0] dstr_mag;
    logic        is_div;
    logic        is_last_op;

    assign prod   = {mhi_reg, mlo_reg};
    assign msum   = {1'b0, mhi_reg} + (mlo_reg[0] ? {1'b0, ma_reg} : 65'd0);
    assign dshift = {drem_reg, dn_reg[63]};
    assign dge    = dshift >= {1'b0, dd_reg};
    assign sin_r  = prod[61:30];
    assign sin_clamped = (sin_r > 32'(ONE_Q30)) ? 32'(ONE_Q30) : sin_r;
    assign vel_mag  = {1'b0, prod[76:30]};
    assign dstr_mag = prod[62:16];
    assign is_div   = (op_reg == OP_QX) || (op_reg == OP_QY);
    assign is_last_op = (op_reg == OP_DY) || (op_reg == OP_QY);

    // Position update with delta clamp and saturation.
    logic signed [63:0] newx, newy;
    logic [31:0]        head_sum;

    assign newx     = 64'(posx_reg) + clamp_delta(dx_reg);
    assign newy     = 64'(posy_reg) + clamp_delta(dy_reg);
    assign head_sum = th0 + dth_reg + HALF_HEADING;

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_SPEED;
            ksub_reg    <= 3'd0;
            sidx_reg    <= 2'd0;
            cnt_reg     <= 6'd0;
            m_valid_reg <= 1'b0;
        end else begin
            // A finished pose loads the output register once it is free.
            if (state_reg == ST_UPD && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_LOAD;
                        op_reg    <= OP_SPEED;
                        ksub_reg  <= 3'd0;
                        sidx_reg  <= 2'd0;
                    end
                end
                ST_LOAD: begin
                    cnt_reg   <= 6'd0;
                    state_reg <= is_div ? ST_DIV : ST_MUL;
                end
                ST_MUL: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == MUL_LAST) begin
                        state_reg <= ST_WB;
                    end
                end
                ST_DIV: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= ST_WB;
                    end
                end
                ST_WB: begin
                    state_reg <= is_last_op ? ST_UPD : ST_LOAD;
                    unique case (op_reg)
                        OP_SPEED: op_reg <= OP_DTH;
                        OP_DTH:   op_reg <= OP_SIN;
                        OP_SIN: begin
                            if (ksub_reg != SIN_LAST_STEP) begin
                                ksub_reg <= ksub_reg + 3'd1;
                            end else begin
                                ksub_reg <= 3'd0;
                                if (sidx_reg == 2'd3) begin
                                    op_reg <= OP_VX;
                                end else begin
                                    sidx_reg <= sidx_reg + 2'd1;
                                end
                            end
                        end
                        OP_VX: op_reg <= OP_VY;
                        OP_VY: op_reg <= (omega_reg == 24'sd0) ? OP_DX : OP_W;
                        OP_DX: op_reg <= OP_DY;
                        OP_W:  op_reg <= OP_AX;
                        OP_AX: op_reg <= OP_QX;
                        OP_QX: op_reg <= OP_AY;
                        OP_AY: op_reg <= OP_QY;
                        default: ;
                    endcase
                end
                ST_UPD: begin
                    // Hold the new pose until the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Configuration register and pose state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spp_reg  <= 32'd0;
            posx_reg <= 32'sd0;
            posy_reg <= 32'sd0;
            head_reg <= 16'd0;
        end else begin
            if (cfg_valid) begin
                spp_reg <= cfg_data;
            end
            if (state_reg == ST_UPD && (!m_valid_reg || m_ready)) begin
                posx_reg <= sat32(newx);
                posy_reg <= sat32(newy);
                head_reg <= head_sum[31:16];
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            pulse_reg <= s_pulse_count;
            omega_reg <= s_yaw_rate;
            dt_reg    <= s_elapsed_time;
        end

        if (state_reg == ST_LOAD) begin
            ma_reg   <= op_a;
            mhi_reg  <= 64'd0;
            mlo_reg  <= op_b;
            dn_reg   <= num_reg;
            drem_reg <= 24'd0;
            dd_reg   <= omega_mag;
        end

        if (state_reg == ST_MUL) begin
            mhi_reg <= msum[64:1];
            mlo_reg <= {msum[0], mlo_reg[31:1]};
        end

        if (state_reg == ST_DIV) begin
            drem_reg <= dge ? 24'(dshift - {1'b0, dd_reg}) : dshift[23:0];
            dn_reg   <= {dn_reg[62:0], dge};
        end

        if (state_reg == ST_WB) begin
            unique case (op_reg)
                OP_SPEED: begin
                    vmag_reg <= prod[47:0];
                    vneg_reg <= pulse_reg[15];
                end
                OP_DTH: dth_reg <= omega_reg[23] ? 32'(-prod[31:0]) : prod[31:0];
                OP_SIN: begin
                    if (ksub_reg == 3'd0) begin
                        x2_reg <= prod[60:30];
                    end else if (ksub_reg == SIN_LAST_STEP) begin
                        sin_reg[sidx_reg] <= sin_ang[31] ? 32'(-sin_clamped) : sin_clamped;
                    end else begin
                        t_reg <= sin_coef(ksub_reg) - prod[61:30];
                    end
                end
                OP_VX: vx_reg <= (vneg_reg ^ sin_reg[1][31]) ? 48'(-vel_mag) : vel_mag;
                OP_VY: vy_reg <= (vneg_reg ^ sin_reg[0][31]) ? 48'(-vel_mag) : vel_mag;
                OP_DX: dx_reg <= vx_reg[47] ? -64'(dstr_mag) : 64'(dstr_mag);
                OP_DY: dy_reg <= vy_reg[47] ? -64'(dstr_mag) : 64'(dstr_mag);
                OP_W:  w_reg  <= prod[76:16];
                OP_AX: begin
                    num_reg    <= {2'b00, prod[91:30]};
                    numneg_reg <= vneg_reg ^ diffx[32];
                end
                OP_AY: begin
                    num_reg    <= {2'b00, prod[91:30]};
                    numneg_reg <= vneg_reg ^ diffy[32];
                end
                OP_QX: dx_reg <= (numneg_reg ^ omega_reg[23]) ? -dn_reg : dn_reg;
                OP_QY: dy_reg <= (numneg_reg ^ omega_reg[23]) ? -dn_reg : dn_reg;
                default: ;
            endcase
        end

        if (state_reg == ST_UPD && (!m_valid_reg || m_ready)) begin
            outx_reg  <= sat32(newx);
            outy_reg  <= sat32(newy);
            outh_reg  <= head_sum[31:16];
            outvx_reg <= sat32(64'(vx_reg));
            outvy_reg <= sat32(64'(vy_reg));
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_pos_x   = outx_reg;
    assign m_pos_y   = outy_reg;
    assign m_heading = outh_reg;
    assign m_vel_x   = outvx_reg;
    assign m_vel_y   = outvy_reg;

endmodule

FILE: hdl/arc_odometry_integrator_checker.sv
// Port-level checker for the arc odometry integrator core.
// Depends on arcodo_pkg and is bound to arc_odometry_integrator_core.
module arc_odometry_integrator_checker
    import arcodo_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_pos_x,
    input logic [15:0]        m_heading
);

    // A result beat is never offered in the cycle after reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The core takes one update at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted beat");

    // A new result only follows a busy period.
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without work");

    // A stalled result holds its pose.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x) && $stable(m_heading))
        else $error("stalled result changed");

endmodule

bind arc_odometry_integrator_core arc_odometry_integrator_checker u_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_pos_x   (m_pos_x),
    .m_heading (m_heading)
);

FILE: bench/tb_arc_odometry_integrator_core.sv
// Self-checking bench for arc_odometry_integrator_core: random and directed pose updates.
// Depends on arcodo_pkg and the core; holds its own bit-exact pose predictor.
module tb_arc_odometry_integrator_core;
    import arcodo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ANG_BITS    = 16;
    localparam longint     MAX_CYCLES  = 64'd40_000_000;
    localparam longint     ARC_CLAMP   = 64'sd1 << 40;
    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] INT64_TOP  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          DRAIN_WAIT = 1000;

    typedef struct packed {
        logic signed [15:0] pulses;
        logic signed [23:0] yaw;
        logic [15:0]        dt;
    } odo_sample_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        hdg;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } pose_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_pulse_count = '0;
    logic signed [23:0] s_yaw_rate = '0;
    logic [15:0] s_elapsed_time = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_pos_x, m_pos_y, m_vel_x, m_vel_y;
    logic [15:0] m_heading;

    // Stimulus waiting to be driven, and poses predicted for accepted beats.
    odo_sample_t sample_q[$];
    pose_t       pose_q[$];

    // Predictor state mirrors the block: speed register plus the pose.
    logic [31:0]        speed_gain = '0;
    logic signed [31:0] model_x = '0;
    logic signed [31:0] model_y = '0;
    logic [15:0]        model_hdg = '0;

    int     mismatches = 0;
    int     beats_in = 0;
    bit     calm = 1'b0;
    bit     squeeze_done = 1'b0;
    longint cycles = 0;

    arc_odometry_integrator_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pulse_count(s_pulse_count), .s_yaw_rate(s_yaw_rate),
        .s_elapsed_time(s_elapsed_time),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pos_x(m_pos_x), .m_pos_y(m_pos_y), .m_heading(m_heading),
        .m_vel_x(m_vel_x), .m_vel_y(m_vel_y)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Product of two signed values shifted right, truncated toward zero and
    // saturated to the signed 64-bit range.
    function automatic longint scaled_product(longint a, longint b, int sh);
        logic        neg;
        logic [63:0] ua, ub;
        logic [127:0] p;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 64'd0 - 64'(a) : 64'(a);
        ub = (b < 0) ? 64'd0 - 64'(b) : 64'(b);
        p = ({64'd0, ua} * {64'd0, ub}) >> sh;
        if (p > {64'd0, INT64_TOP})
            p = {64'd0, INT64_TOP};
        return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
    endfunction

    // Quarter-wave odd polynomial sine of a 32-bit binary angle, Q2.30.
    function automatic longint wave_sine(logic [31:0] angle);
        logic [31:0] a;
        logic [1:0]  quad;
        logic [63:0] x, x2, t, r;
        a = angle >> (32 - ANG_BITS);
        quad = a[ANG_BITS-1 -: 2];
        x = 64'(a & ((32'd1 << (ANG_BITS - 2)) - 1)) << (32 - ANG_BITS);
        if (quad[0])
            x = Q30_ONE - x;
        x2 = (x * x) >> 30;
        t = 64'd5026995 - ((x2 * 64'd172273) >> 30);
        t = 64'd85569306 - ((x2 * t) >> 30);
        t = 64'd693598670 - ((x2 * t) >> 30);
        t = 64'd1686629713 - ((x2 * t) >> 30);
        r = (x * t) >> 30;
        if (r > Q30_ONE)
            r = Q30_ONE;
        return quad[1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint clip_delta(longint d);
        if (d > ARC_CLAMP)
            return ARC_CLAMP;
        if (d < -ARC_CLAMP)
            return -ARC_CLAMP;
        return d;
    endfunction

    // Advances the predicted pose by one sample and returns the expected beat.
    function automatic pose_t advance_pose(odo_sample_t u);
        longint      pul, om, dt, spd, s0, c0, vx, vy, dx, dy, dth, w;
        logic [31:0] th0, th1, hsum;
        pose_t       e;
        pul = longint'(u.pulses);
        om = longint'(u.yaw);
        dt = longint'({48'd0, u.dt});
        spd = pul * longint'({32'd0, speed_gain});
        th0 = {model_hdg, 16'd0};
        s0 = wave_sine(th0);
        c0 = wave_sine(th0 + QUARTER_TURN);
        vx = scaled_product(spd, c0, 30);
        vy = scaled_product(spd, s0, 30);
        dth = 0;
        if (om == 0) begin
            dx = scaled_product(vx, dt, 16);
            dy = scaled_product(vy, dt, 16);
        end else begin
            dth = om * dt;
            th1 = th0 + dth[31:0];
            w = scaled_product(spd, longint'(TURN_PER_RAD_Q16), 16);
            dx = scaled_product(w, wave_sine(th1) - s0, 30) / om;
            dy = scaled_product(w, c0 - wave_sine(th1 + QUARTER_TURN), 30) / om;
        end
        model_x = clip32(longint'(model_x) + clip_delta(dx));
        model_y = clip32(longint'(model_y) + clip_delta(dy));
        hsum = th0 + dth[31:0] + HALF_HEADING;
        model_hdg = hsum[31:16];
        e.x = model_x;
        e.y = model_y;
        e.hdg = model_hdg;
        e.vx = clip32(vx);
        e.vy = clip32(vy);
        return e;
    endfunction

    // Sender: presents queued samples, keeps valid and payload steady until
    // the beat is taken, and inserts short random gaps unless the run is calm.
    int send_gap = 0;
    always @(posedge aclk) begin
        odo_sample_t nxt;
        logic        offer;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pose_q.push_back(advance_pose(sample_q.pop_front()));
                beats_in <= beats_in + 1;
            end
            offer = s_valid && !s_ready;
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(0, 3);
                end else if (sample_q.size() > 0) begin
                    offer = 1'b1;
                    nxt = sample_q[0];
                    s_pulse_count <= nxt.pulses;
                    s_yaw_rate <= nxt.yaw;
                    s_elapsed_time <= nxt.dt;
                end
            end
            s_valid <= offer;
        end
    end

    // Receiver: checks each result beat against the oldest prediction and
    // throttles m_ready. One long hold-off lets the block back up its input.
    int hold_left = 0;
    always @(posedge aclk) begin
        pose_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_pos_x, m_pos_y, m_heading, m_vel_x, m_vel_y};
                if (pose_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result beat x=%0d y=%0d hdg=%0d",
                                 m_pos_x, m_pos_y, m_heading);
                end else begin
                    want = pose_q.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10) begin
                            $display("mismatch exp x=%0d y=%0d h=%0d vx=%0d vy=%0d",
                                     want.x, want.y, want.hdg, want.vx, want.vy);
                            $display("         got x=%0d y=%0d h=%0d vx=%0d vy=%0d",
                                     got.x, got.y, got.hdg, got.vx, got.vy);
                        end
                    end
                end
            end
            if (!squeeze_done && beats_in == 150) begin
                squeeze_done <= 1'b1;
                hold_left <= 3000;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                hold_left <= $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_speed(logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        speed_gain = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic push_sample(int p, int w, int t);
        odo_sample_t u;
        u.pulses = 16'(p);
        u.yaw = 24'(w);
        u.dt = 16'(t);
        sample_q.push_back(u);
    endtask

    // Random samples: mostly modest motion so the pose stays meaningful, with
    // a share of full-range fields to hit saturation and heading wrap.
    task automatic push_random(int n);
        int p, w, t;
        repeat (n) begin
            p = ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 400) - 200;
            case ($urandom_range(0, 3))
                0:       w = 0;
                1:       w = $urandom_range(0, 4) - 2;
                2:       w = $urandom_range(0, 40000) - 20000;
                default: w = $urandom;
            endcase
            t = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2000) : int'($urandom);
            push_sample(p, w, t);
        end
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || pose_q.size() > 0 || s_valid)
            @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, straight and curved paths, zero pulses
        // while turning, zero elapsed time, and positions driven to saturation.
        write_speed(32'h0001_0000);
        push_sample(0, 0, 0);
        push_sample(32767, 0, 65535);
        push_sample(-32768, 0, 65535);
        push_sample(0, 8388607, 65535);
        push_sample(0, -8388608, 65535);
        push_sample(100, 1, 65535);
        push_sample(100, -1, 65535);
        push_sample(32767, 16384, 65535);
        push_sample(-32768, -16384, 65535);
        push_sample(500, 4096, 0);
        push_sample(1, 65536, 1);
        push_sample(32767, 8388607, 65535);
        push_sample(-32768, 8388607, 1);
        drain();
        write_speed(32'hFFFF_FFFF);
        push_sample(32767, 0, 65535);
        push_sample(32767, 0, 65535);
        push_sample(-32768, 0, 65535);
        push_sample(-32768, 5, 65535);
        push_sample(32767, -8388608, 65535);
        push_sample(12345, 3, 40000);
        drain();

        write_speed(32'd0);
        push_random(380);
        drain();
        write_speed(32'hFFFF_FFFF);
        push_random(380);
        drain();
        write_speed($urandom_range(1, 1 << 20));
        push_random(380);
        drain();
        write_speed($urandom);
        push_random(380);
        drain();
        calm = 1'b1;
        write_speed(32'h0001_0000);
        push_random(400);
        drain();

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && pose_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/arcodo_pkg.sv
hdl/arc_odometry_integrator_core.sv
hdl/arc_odometry_integrator_checker.sv
bench/tb_arc_odometry_integrator_core.sv
